>>> src/assert_macros.svh
// Assertion macros shared by the line writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> src/bwr_pkg.sv
// Shared types, constants and helper functions of the line pixel writer.
`timescale 1ns / 1ps
`default_nettype none
package bwr_pkg;

	localparam int COORD_W       = 6;
	localparam int DELTA_W       = 7;
	localparam int ERR_W         = 10;
	localparam int COLOR_W       = 32;
	localparam int OFFSET_W      = 22;
	localparam int PITCH_W       = 16;
	localparam int BPP_W         = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int COORD_BITS_DEF = 6;
	localparam int FIFO_DEPTH_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 2'd2;

	localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd256;
	localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
	localparam logic [BPP_W-1:0]   BPP_MIN     = 3'd1;
	localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;

	// A line command after classification, in major/minor axis terms.
	typedef struct packed {
		logic [COORD_W-1:0] major_start;
		logic [COORD_W-1:0] minor_start;
		logic [COORD_W-1:0] major_end;
		logic [DELTA_W-1:0] major_delta;
		logic [DELTA_W-1:0] minor_delta;
		logic               minor_dir_down;
		logic               axes_swapped;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	// Clamp the stored bytes per pixel into 1..4.
	function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] bpp);
		logic [BPP_W-1:0] n;
		n = bpp;
		if (bpp < BPP_MIN) begin
			n = BPP_MIN;
		end else if (bpp > BPP_MAX) begin
			n = BPP_MAX;
		end
		return n;
	endfunction

	// Place the low color bytes into memory lanes; unused lanes are zero.
	function automatic logic [COLOR_W-1:0] lane_data(input logic [COLOR_W-1:0] color,
			input logic [BPP_W-1:0] n, input logic be);
		logic [COLOR_W-1:0] out;
		logic [BPP_W-1:0]   src;
		out = '0;
		src = '0;
		for (int i = 0; i < 4; i++) begin
			if (BPP_W'(i) < n) begin
				src = be ? BPP_W'(n - BPP_W'(1) - BPP_W'(i)) : BPP_W'(i);
				case (src[1:0])
					2'd0: out[8*i +: 8] = color[7:0];
					2'd1: out[8*i +: 8] = color[15:8];
					2'd2: out[8*i +: 8] = color[23:16];
					default: out[8*i +: 8] = color[31:24];
				endcase
			end
		end
		return out;
	endfunction

endpackage
`default_nettype wire

>>> src/bwr_front.sv
// Command front end: accepts a line request and classifies its axes and direction.
`timescale 1ns / 1ps
`default_nettype none
module bwr_front #(
	parameter int COORD_BITS = bwr_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [bwr_pkg::COORD_W-1:0]     start_x,
	input  wire logic [bwr_pkg::COORD_W-1:0]     start_y,
	input  wire logic [bwr_pkg::COORD_W-1:0]     end_x,
	input  wire logic [bwr_pkg::COORD_W-1:0]     end_y,
	input  wire logic [bwr_pkg::COLOR_W-1:0]     color,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output bwr_pkg::cmd_t                        push_cmd
);

	localparam int CW = bwr_pkg::COORD_W;
	localparam logic [CW-1:0] CMASK = CW'((1 << COORD_BITS) - 1);

	logic [CW-1:0] x1, y1, x2, y2, dx, dy;
	logic [CW-1:0] a1, b1, a2, b2;
	logic          swapped;
	bwr_pkg::cmd_t cmd_d;
	bwr_pkg::cmd_t cmd_s1;
	logic          valid_s1;

	always_comb begin
		x1 = start_x & CMASK;
		y1 = start_y & CMASK;
		x2 = end_x & CMASK;
		y2 = end_y & CMASK;
		dx = (x1 > x2) ? (x1 - x2) : (x2 - x1);
		dy = (y1 > y2) ? (y1 - y2) : (y2 - y1);
		swapped = dy > dx;
		// Order endpoints so that the major coordinate rises.
		if ((swapped ? y1 : x1) > (swapped ? y2 : x2)) begin
			a1 = swapped ? y2 : x2;
			b1 = swapped ? x2 : y2;
			a2 = swapped ? y1 : x1;
			b2 = swapped ? x1 : y1;
		end else begin
			a1 = swapped ? y1 : x1;
			b1 = swapped ? x1 : y1;
			a2 = swapped ? y2 : x2;
			b2 = swapped ? x2 : y2;
		end
		cmd_d.major_start    = a1;
		cmd_d.minor_start    = b1;
		cmd_d.major_end      = a2;
		cmd_d.major_delta    = bwr_pkg::DELTA_W'(a2 - a1);
		cmd_d.minor_delta    = bwr_pkg::DELTA_W'((b1 > b2) ? (b1 - b2) : (b2 - b1));
		cmd_d.minor_dir_down = !(b1 < b2);
		cmd_d.axes_swapped   = swapped;
		cmd_d.color          = color;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule
`default_nettype wire

>>> src/bwr_cmd_fifo.sv
// Short command queue between the front end and the pixel walker.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bwr_cmd_fifo #(
	parameter int DEPTH = bwr_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire bwr_pkg::cmd_t push_cmd,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output bwr_pkg::cmd_t      pop_cmd
);

	// DEPTH must be a power of two so that the pointers wrap naturally; not enforced.
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	bwr_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != FULL;
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	`ASSERT_NEVER(a_fifo_overfill, count_q > FULL, "command queue count beyond depth")
	`ASSERT_CLK(a_fifo_drain, pop && !push |=> count_q == $past(count_q) - 1'b1, "queue count did not drop on pop")

endmodule
`default_nettype wire

>>> src/bwr_back.sv
// Pixel walker: steps a line with the doubled Bresenham error and forms each pixel write.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bwr_back #(
	parameter int COORD_BITS = bwr_pkg::COORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pop_valid,
	output logic                                pop_ready,
	input  wire bwr_pkg::cmd_t                  pop_cmd,
	input  wire logic [bwr_pkg::PITCH_W-1:0]    row_pitch,
	input  wire logic [bwr_pkg::BPP_W-1:0]      bytes_per_pixel,
	input  wire logic                           big_endian,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [bwr_pkg::COORD_W-1:0]         pixel_x,
	output logic [bwr_pkg::COORD_W-1:0]         pixel_y,
	output logic [bwr_pkg::OFFSET_W-1:0]        byte_offset,
	output logic [bwr_pkg::COLOR_W-1:0]         write_data,
	output logic [bwr_pkg::BPP_W-1:0]           byte_count,
	output logic                                last
);

	localparam int CW = bwr_pkg::COORD_W;
	localparam int DW = bwr_pkg::DELTA_W;
	localparam int EW = bwr_pkg::ERR_W;
	localparam int OW = bwr_pkg::OFFSET_W;
	localparam int PW = bwr_pkg::PITCH_W;
	localparam int BW = bwr_pkg::BPP_W;
	localparam logic [CW-1:0] CMASK = CW'((1 << COORD_BITS) - 1);

	logic                   busy_q;
	logic [CW-1:0]          major_q, minor_q, end_q;
	logic [DW-1:0]          major_delta_q, minor_delta_q;
	logic signed [EW-1:0]   err_q;
	logic                   dir_down_q, swapped_q;
	logic [bwr_pkg::COLOR_W-1:0] color_q;

	logic                   out_valid_q;
	logic [CW-1:0]          pixel_x_q, pixel_y_q;
	logic [OW-1:0]          offset_q;
	logic [bwr_pkg::COLOR_W-1:0] data_q;
	logic [BW-1:0]          count_q;
	logic                   last_q;

	logic                   slot_free, emit, load;
	logic [CW-1:0]          px, py, major_next, minor_next;
	logic [BW-1:0]          nbytes;
	logic signed [EW-1:0]   err_sub, err_next;
	logic                   pix_last;
	logic [OW-1:0]          row_term, col_term;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy_q && slot_free;
	assign pop_ready = !busy_q;
	assign load      = pop_valid && pop_ready;

	always_comb begin
		px         = swapped_q ? minor_q : major_q;
		py         = swapped_q ? major_q : minor_q;
		nbytes     = bwr_pkg::clamp_bpp(bytes_per_pixel);
		major_next = CW'(major_q + 1'b1) & CMASK;
		pix_last   = major_next == end_q;
		err_sub    = err_q - $signed({{(EW-DW-1){1'b0}}, minor_delta_q, 1'b0});
		err_next   = err_sub;
		minor_next = minor_q;
		if (err_sub < 0) begin
			err_next   = err_sub + $signed({{(EW-DW-1){1'b0}}, major_delta_q, 1'b0});
			minor_next = (dir_down_q ? CW'(minor_q - 1'b1) : CW'(minor_q + 1'b1)) & CMASK;
		end
		row_term = OW'({{(OW-PW){1'b0}}, row_pitch} * {{(OW-CW){1'b0}}, py});
		col_term = OW'({{(OW-CW){1'b0}}, px} * {{(OW-BW){1'b0}}, nbytes});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				// A line whose endpoints share the major coordinate plots nothing.
				busy_q <= pop_cmd.major_start != pop_cmd.major_end;
			end else if (emit && pix_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			major_q       <= pop_cmd.major_start;
			minor_q       <= pop_cmd.minor_start;
			end_q         <= pop_cmd.major_end;
			major_delta_q <= pop_cmd.major_delta;
			minor_delta_q <= pop_cmd.minor_delta;
			err_q         <= $signed({{(EW-DW){1'b0}}, pop_cmd.major_delta});
			dir_down_q    <= pop_cmd.minor_dir_down;
			swapped_q     <= pop_cmd.axes_swapped;
			color_q       <= pop_cmd.color;
		end else if (emit) begin
			major_q <= major_next;
			minor_q <= minor_next;
			err_q   <= err_next;
		end
		if (emit) begin
			pixel_x_q <= px;
			pixel_y_q <= py;
			offset_q  <= OW'(row_term + col_term);
			data_q    <= bwr_pkg::lane_data(color_q, nbytes, big_endian);
			count_q   <= nbytes;
			last_q    <= pix_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign byte_offset = offset_q;
	assign write_data  = data_q;
	assign byte_count  = count_q;
	assign last        = last_q;

	`ASSERT_NEVER(a_busy_at_end, busy_q && major_q == end_q, "walker busy at the end coordinate")
	`ASSERT_CLK(a_last_ends_line, emit && pix_last |=> !busy_q && out_valid_q && last_q, "last pixel did not end the line")
	`ASSERT_CLK(a_mid_keeps_busy, emit && !pix_last |=> busy_q && !last_q, "walker stopped inside a line")

endmodule
`default_nettype wire

>>> src/bresenham_line_pixel_writer_core.sv
// Top level of the Bresenham line pixel writer: configuration, front end, queue and walker.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    start_x start_y end_x end_y color
//   out      out_valid/out_ready  pixel_x pixel_y byte_offset write_data byte_count last
//   cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// For each line the walker first loads the command from the queue, once it is idle,
// then emits one pixel per cycle from the single error update and the offset multiplies.
// The front end adds one register stage; the queue lets it take new requests while
// the walker is busy. Stalls on out_ready hold the walker; cfg_ready is always high.
// Reset clears all handshake state and loads the register reset values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module bresenham_line_pixel_writer_core #(
	parameter int COORD_BITS = bwr_pkg::COORD_BITS_DEF,
	parameter int FIFO_DEPTH = bwr_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bwr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bwr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [bwr_pkg::COORD_W-1:0]      start_x,
	input  wire logic [bwr_pkg::COORD_W-1:0]      start_y,
	input  wire logic [bwr_pkg::COORD_W-1:0]      end_x,
	input  wire logic [bwr_pkg::COORD_W-1:0]      end_y,
	input  wire logic [bwr_pkg::COLOR_W-1:0]      color,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [bwr_pkg::COORD_W-1:0]           pixel_x,
	output logic [bwr_pkg::COORD_W-1:0]           pixel_y,
	output logic [bwr_pkg::OFFSET_W-1:0]          byte_offset,
	output logic [bwr_pkg::COLOR_W-1:0]           write_data,
	output logic [bwr_pkg::BPP_W-1:0]             byte_count,
	output logic                                  last
);

	logic [bwr_pkg::PITCH_W-1:0] row_pitch_q;
	logic [bwr_pkg::BPP_W-1:0]   bpp_q;
	logic                        big_endian_q;

	logic          push_valid, push_ready, pop_valid, pop_ready;
	bwr_pkg::cmd_t push_cmd, pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q  <= bwr_pkg::PITCH_RESET;
			bpp_q        <= bwr_pkg::BPP_RESET;
			big_endian_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bwr_pkg::REG_ROW_PITCH:  row_pitch_q  <= cfg_data;
				bwr_pkg::REG_BPP:        bpp_q        <= cfg_data[bwr_pkg::BPP_W-1:0];
				bwr_pkg::REG_BIG_ENDIAN: big_endian_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bwr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.color      (color),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	bwr_cmd_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	bwr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_cmd         (pop_cmd),
		.row_pitch       (row_pitch_q),
		.bytes_per_pixel (bpp_q),
		.big_endian      (big_endian_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.byte_offset     (byte_offset),
		.write_data      (write_data),
		.byte_count      (byte_count),
		.last            (last)
	);

endmodule
`default_nettype wire
